@@ rtl/transition_density_matrix_core_assert.svh @@
// Assertion macros used by tdm_back of the transition density matrix RTL.
// Depends on nothing; the macros expand to nothing when SYNTH is defined.
`ifndef TRANSITION_DENSITY_MATRIX_CORE_ASSERT_SVH
`define TRANSITION_DENSITY_MATRIX_CORE_ASSERT_SVH
`ifndef SYNTH
`define TDM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define TDM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define TDM_ASSERT(lbl, clk, rst_n, prop)
`define TDM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/tdm_pkg.sv @@
// Types, sizes and codes of the transition density matrix core.
// Used by every module of the block but tdm_ram; depends on nothing.
package tdm_pkg;

    localparam int MAX_BASIS = 64;
    localparam int MAX_OCC   = 32;
    localparam int MAX_VIRT  = 32;

    localparam int NUM_BANDS = MAX_OCC + MAX_VIRT;
    localparam int COEF_DEPTH = NUM_BANDS * MAX_BASIS;
    localparam int AMP_DEPTH  = MAX_OCC * MAX_VIRT;
    localparam int COEF_AW = $clog2(COEF_DEPTH);
    localparam int AMP_AW  = $clog2(AMP_DEPTH);
    localparam int ADDR_W  = (COEF_AW > AMP_AW) ? COEF_AW : AMP_AW;

    localparam int OCNT_W = $clog2(MAX_OCC + 1);
    localparam int VCNT_W = $clog2(MAX_VIRT + 1);
    localparam int NB_W   = $clog2(MAX_BASIS + 1);
    localparam int BASIS_W = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 16;
    localparam int WORD_W = 2 * VAL_W;
    localparam int FRAC   = 15;
    localparam int ROUND_HALF = 16384;
    localparam int RECIP_W = 16;
    localparam int OUT_W  = 48;

    localparam int PR_W  = 2 * VAL_W + 1;
    localparam int TRM_W = PR_W + VAL_W + 1;
    localparam int ACC_W = TRM_W + $clog2(AMP_DEPTH + 1);
    localparam int RES_W = ACC_W - FRAC;
    localparam int PRD_W = RES_W + RECIP_W + 1;
    localparam int FIN_W = PRD_W - FRAC;
    localparam int EXT_W = ((FIN_W > OUT_W) ? FIN_W : OUT_W) + 1;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = 1;
    localparam int FQ_CW    = 2;

    localparam logic [OP_W-1:0] OP_COEF = 2'd0;
    localparam logic [OP_W-1:0] OP_AMP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_NOCC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NVIRT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NBASIS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CPLX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RENORM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP  = 3'd5;

    typedef enum logic [1:0] {
        K_COEF,
        K_AMP,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [WORD_W-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic [OCNT_W-1:0]  nocc;
        logic [VCNT_W-1:0]  nvirt;
        logic [NB_W-1:0]    nbasis;
        logic               cplx;
        logic               renorm;
        logic [RECIP_W-1:0] recip;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OCC,
        S_VIR,
        S_DRAIN,
        S_ROUND,
        S_SCALE,
        S_FIN
    } t_state;

endpackage

@@ rtl/tdm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/tdm_front.sv @@
// Front end: accepts items, drops unused ones and out-of-range loads, forms memory
// addresses and queues commands for the back end. Depends on tdm_pkg.
module tdm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [tdm_pkg::OP_W-1:0]   i_op,
    input  logic [tdm_pkg::IDX_W-1:0]  i_row,
    input  logic [tdm_pkg::IDX_W-1:0]  i_col,
    input  logic signed [tdm_pkg::VAL_W-1:0] i_value_re,
    input  logic signed [tdm_pkg::VAL_W-1:0] i_value_im,
    output logic                       o_cmd_valid,
    output tdm_pkg::t_cmd              o_cmd,
    input  logic                       i_take
);
    tdm_pkg::t_cmd                 r_q [tdm_pkg::FQ_DEPTH];
    logic [tdm_pkg::FQ_AW-1:0]     r_wp;
    logic [tdm_pkg::FQ_AW-1:0]     r_rp;
    logic [tdm_pkg::FQ_CW-1:0]     r_cnt;
    tdm_pkg::t_cmd                 cmd;
    logic                          keep;
    logic                          wr;
    logic                          rd;

    always_comb begin
        cmd.row  = i_row;
        cmd.col  = i_col;
        cmd.word = {i_value_im, i_value_re};
        cmd.kind = tdm_pkg::K_READ;
        cmd.addr = '0;
        keep     = 1'b0;
        case (i_op)
            tdm_pkg::OP_COEF: begin
                cmd.kind = tdm_pkg::K_COEF;
                cmd.addr = tdm_pkg::ADDR_W'(32'(i_row) * tdm_pkg::MAX_BASIS + 32'(i_col));
                keep = (32'(i_row) < tdm_pkg::NUM_BANDS) && (32'(i_col) < tdm_pkg::MAX_BASIS);
            end
            tdm_pkg::OP_AMP: begin
                cmd.kind = tdm_pkg::K_AMP;
                cmd.addr = tdm_pkg::ADDR_W'(32'(i_row) * tdm_pkg::MAX_VIRT + 32'(i_col));
                keep = (32'(i_row) < tdm_pkg::MAX_OCC) && (32'(i_col) < tdm_pkg::MAX_VIRT);
            end
            tdm_pkg::OP_READ: begin
                cmd.kind = tdm_pkg::K_READ;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_cnt == tdm_pkg::FQ_CW'(tdm_pkg::FQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = i_push && !o_full && keep;
    assign rd          = i_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

@@ rtl/tdm_back.sv @@
// Back end: writes loads into the stores, runs the multiply-accumulate
// sequence for reads and holds the result. Depends on tdm_pkg, tdm_ram.
`include "transition_density_matrix_core_assert.svh"
module tdm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tdm_pkg::t_cfg               i_cfg,
    input  logic                        i_cmd_valid,
    input  tdm_pkg::t_cmd               i_cmd,
    output logic                        o_take,
    input  logic                        i_pop,
    output logic                        o_valid,
    output logic signed [tdm_pkg::OUT_W-1:0] o_dm_re,
    output logic signed [tdm_pkg::OUT_W-1:0] o_dm_im,
    output logic                        o_saturated
);
    localparam logic signed [tdm_pkg::EXT_W-1:0] SAT_HI =
        {{(tdm_pkg::EXT_W - tdm_pkg::OUT_W + 1){1'b0}}, {(tdm_pkg::OUT_W - 1){1'b1}}};
    localparam logic signed [tdm_pkg::EXT_W-1:0] SAT_LO = ~SAT_HI;

    tdm_pkg::t_state                r_state, n_state;
    logic [tdm_pkg::OCNT_W-1:0]     r_j, n_j;
    logic [tdm_pkg::VCNT_W-1:0]     r_b, n_b;
    logic [tdm_pkg::BASIS_W-1:0]    r_mu, n_mu;
    logic [tdm_pkg::BASIS_W-1:0]    r_nu, n_nu;
    logic                           r_zero, n_zero;
    logic                           take, issue_occ, issue_vir, clr, do_round, do_scale, fin;
    logic                           oor, scale_en;

    logic                           r_v1_occ, r_v1_vir, r_v2, r_v3, r_ov;
    logic [tdm_pkg::COEF_AW-1:0]    coef_raddr;
    logic [tdm_pkg::AMP_AW-1:0]     amp_raddr;
    logic [tdm_pkg::WORD_W-1:0]     coef_rd, amp_rd;
    logic                           coef_we, amp_we;

    logic signed [tdm_pkg::VAL_W-1:0] r_cr, r_ci, r_vr, r_vi, xr, xi;
    logic signed [tdm_pkg::PR_W-1:0]  r_pr, r_pi, pr, pi;
    logic signed [tdm_pkg::TRM_W-1:0] r_tre, r_tim, tre, tim;
    logic signed [tdm_pkg::ACC_W-1:0] r_acc_re, r_acc_im, rnd_re, rnd_im;
    logic signed [tdm_pkg::RES_W-1:0] r_res_re, r_res_im;
    logic signed [tdm_pkg::PRD_W-1:0] r_prd_re, r_prd_im, prnd_re, prnd_im;
    logic signed [tdm_pkg::FIN_W-1:0] fin_re, fin_im;
    logic signed [tdm_pkg::EXT_W-1:0] ext_re, ext_im;
    logic signed [tdm_pkg::OUT_W-1:0] r_dm_re, r_dm_im, sat_re, sat_im;
    logic                           r_sat, sat_flag;

    assign oor = ({1'b0, i_cmd.row} >= (tdm_pkg::IDX_W + 1)'(i_cfg.nbasis))
              || ({1'b0, i_cmd.col} >= (tdm_pkg::IDX_W + 1)'(i_cfg.nbasis));
    assign scale_en = i_cfg.cplx && i_cfg.renorm;

    always_comb begin
        n_state = r_state;
        n_j = r_j;
        n_b = r_b;
        n_mu = r_mu;
        n_nu = r_nu;
        n_zero = r_zero;
        take = 1'b0;
        issue_occ = 1'b0;
        issue_vir = 1'b0;
        clr = 1'b0;
        do_round = 1'b0;
        do_scale = 1'b0;
        fin = 1'b0;
        case (r_state)
            tdm_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    take = 1'b1;
                    if (i_cmd.kind == tdm_pkg::K_READ) begin
                        clr  = 1'b1;
                        n_mu = tdm_pkg::BASIS_W'(i_cfg.cplx ? i_cmd.col : i_cmd.row);
                        n_nu = tdm_pkg::BASIS_W'(i_cfg.cplx ? i_cmd.row : i_cmd.col);
                        n_j  = '0;
                        n_b  = '0;
                        if (oor) begin
                            n_zero  = 1'b1;
                            n_state = tdm_pkg::S_FIN;
                        end else if (i_cfg.nocc == '0 || i_cfg.nvirt == '0) begin
                            n_zero  = 1'b0;
                            n_state = tdm_pkg::S_DRAIN;
                        end else begin
                            n_zero  = 1'b0;
                            n_state = tdm_pkg::S_OCC;
                        end
                    end
                end
            end
            tdm_pkg::S_OCC: begin
                issue_occ = 1'b1;
                n_b = '0;
                n_state = tdm_pkg::S_VIR;
            end
            tdm_pkg::S_VIR: begin
                issue_vir = 1'b1;
                if (r_b == i_cfg.nvirt - 1'b1) begin
                    if (r_j == i_cfg.nocc - 1'b1) begin
                        n_state = tdm_pkg::S_DRAIN;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = tdm_pkg::S_OCC;
                    end
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
            tdm_pkg::S_DRAIN: begin
                if (!r_v1_occ && !r_v1_vir && !r_v2 && !r_v3) begin
                    n_state = tdm_pkg::S_ROUND;
                end
            end
            tdm_pkg::S_ROUND: begin
                do_round = 1'b1;
                n_state = scale_en ? tdm_pkg::S_SCALE : tdm_pkg::S_FIN;
            end
            tdm_pkg::S_SCALE: begin
                do_scale = 1'b1;
                n_state = tdm_pkg::S_FIN;
            end
            tdm_pkg::S_FIN: begin
                if (!r_ov || i_pop) begin
                    fin = 1'b1;
                    n_state = tdm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tdm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdm_pkg::S_IDLE;
            r_j <= '0;
            r_b <= '0;
            r_zero <= 1'b0;
            r_v1_occ <= 1'b0;
            r_v1_vir <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_j <= n_j;
            r_b <= n_b;
            r_zero <= n_zero;
            r_v1_occ <= issue_occ;
            r_v1_vir <= issue_vir;
            r_v2 <= r_v1_vir;
            r_v3 <= r_v2;
            if (fin) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mu <= n_mu;
        r_nu <= n_nu;
    end

    assign o_take  = take;
    assign coef_we = take && (i_cmd.kind == tdm_pkg::K_COEF);
    assign amp_we  = take && (i_cmd.kind == tdm_pkg::K_AMP);
    assign coef_raddr = issue_occ
        ? tdm_pkg::COEF_AW'(32'(r_j) * tdm_pkg::MAX_BASIS + 32'(r_mu))
        : tdm_pkg::COEF_AW'((32'(i_cfg.nocc) + 32'(r_b)) * tdm_pkg::MAX_BASIS + 32'(r_nu));
    assign amp_raddr = tdm_pkg::AMP_AW'(32'(r_j) * tdm_pkg::MAX_VIRT + 32'(r_b));

    tdm_ram #(.WIDTH(tdm_pkg::WORD_W), .DEPTH(tdm_pkg::COEF_DEPTH)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (i_cmd.addr[tdm_pkg::COEF_AW-1:0]),
        .i_wdata (i_cmd.word),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rd)
    );

    tdm_ram #(.WIDTH(tdm_pkg::WORD_W), .DEPTH(tdm_pkg::AMP_DEPTH)) u_amp_ram (
        .i_clk   (i_clk),
        .i_we    (amp_we),
        .i_waddr (i_cmd.addr[tdm_pkg::AMP_AW-1:0]),
        .i_wdata (i_cmd.word),
        .i_raddr (amp_raddr),
        .o_rdata (amp_rd)
    );

    assign xr  = $signed(amp_rd[tdm_pkg::VAL_W-1:0]);
    assign xi  = i_cfg.cplx ? $signed(amp_rd[tdm_pkg::WORD_W-1:tdm_pkg::VAL_W]) : '0;
    assign pr  = r_cr * xr + r_ci * xi;
    assign pi  = r_cr * xi - r_ci * xr;
    assign tre = r_pr * r_vr - r_pi * r_vi;
    assign tim = r_pr * r_vi + r_pi * r_vr;
    assign rnd_re = r_acc_re + $signed(tdm_pkg::ACC_W'(tdm_pkg::ROUND_HALF));
    assign rnd_im = r_acc_im + $signed(tdm_pkg::ACC_W'(tdm_pkg::ROUND_HALF));
    assign prnd_re = r_prd_re + $signed(tdm_pkg::PRD_W'(tdm_pkg::ROUND_HALF));
    assign prnd_im = r_prd_im + $signed(tdm_pkg::PRD_W'(tdm_pkg::ROUND_HALF));

    always_comb begin
        if (r_zero) begin
            fin_re = '0;
            fin_im = '0;
        end else if (scale_en) begin
            fin_re = tdm_pkg::FIN_W'(prnd_re >>> tdm_pkg::FRAC);
            fin_im = tdm_pkg::FIN_W'(prnd_im >>> tdm_pkg::FRAC);
        end else begin
            fin_re = tdm_pkg::FIN_W'(r_res_re);
            fin_im = tdm_pkg::FIN_W'(r_res_im);
        end
        ext_re = tdm_pkg::EXT_W'(fin_re);
        ext_im = tdm_pkg::EXT_W'(fin_im);
        sat_flag = 1'b0;
        if (ext_re > SAT_HI) begin
            sat_re = tdm_pkg::OUT_W'(SAT_HI);
            sat_flag = 1'b1;
        end else if (ext_re < SAT_LO) begin
            sat_re = tdm_pkg::OUT_W'(SAT_LO);
            sat_flag = 1'b1;
        end else begin
            sat_re = tdm_pkg::OUT_W'(ext_re);
        end
        if (ext_im > SAT_HI) begin
            sat_im = tdm_pkg::OUT_W'(SAT_HI);
            sat_flag = 1'b1;
        end else if (ext_im < SAT_LO) begin
            sat_im = tdm_pkg::OUT_W'(SAT_LO);
            sat_flag = 1'b1;
        end else begin
            sat_im = tdm_pkg::OUT_W'(ext_im);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1_occ) begin
            r_cr <= $signed(coef_rd[tdm_pkg::VAL_W-1:0]);
            r_ci <= i_cfg.cplx ? $signed(coef_rd[tdm_pkg::WORD_W-1:tdm_pkg::VAL_W]) : '0;
        end
        if (r_v1_vir) begin
            r_pr <= pr;
            r_pi <= pi;
            r_vr <= $signed(coef_rd[tdm_pkg::VAL_W-1:0]);
            r_vi <= i_cfg.cplx ? $signed(coef_rd[tdm_pkg::WORD_W-1:tdm_pkg::VAL_W]) : '0;
        end
        if (r_v2) begin
            r_tre <= tre;
            r_tim <= tim;
        end
        if (clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v3) begin
            r_acc_re <= r_acc_re + tdm_pkg::ACC_W'(r_tre);
            r_acc_im <= r_acc_im + tdm_pkg::ACC_W'(r_tim);
        end
        if (do_round) begin
            r_res_re <= tdm_pkg::RES_W'(rnd_re >>> tdm_pkg::FRAC);
            r_res_im <= i_cfg.cplx ? tdm_pkg::RES_W'(rnd_im >>> tdm_pkg::FRAC) : '0;
        end
        if (do_scale) begin
            r_prd_re <= r_res_re * $signed({1'b0, i_cfg.recip});
            r_prd_im <= r_res_im * $signed({1'b0, i_cfg.recip});
        end
        if (fin) begin
            r_dm_re <= sat_re;
            r_dm_im <= sat_im;
            r_sat   <= sat_flag;
        end
    end

    assign o_valid     = r_ov;
    assign o_dm_re     = r_dm_re;
    assign o_dm_im     = r_dm_im;
    assign o_saturated = r_sat;

    `TDM_ASSERT(a_fin_slot_free, i_clk, i_rst_n, fin |-> (!r_ov || i_pop))
    `TDM_ASSERT(a_fin_pipe_empty, i_clk, i_rst_n,
        (r_state == tdm_pkg::S_FIN) |-> (!r_v1_vir && !r_v2 && !r_v3))
    `TDM_ASSERT(a_vir_in_range, i_clk, i_rst_n,
        (r_state == tdm_pkg::S_VIR) |-> (r_b < i_cfg.nvirt && r_j < i_cfg.nocc))
    `TDM_ASSERT(a_take_only_idle, i_clk, i_rst_n,
        take |=> ($past(r_state) == tdm_pkg::S_IDLE))
endmodule

@@ rtl/transition_density_matrix_core.sv @@
// Top level of the transition density matrix core: configuration registers,
// front end and back end. Depends on tdm_pkg, tdm_front, tdm_back.
//
// Each load of a coefficient or an amplitude is written in the back end as it is
// taken. During a read the shared multiply-accumulate pipeline takes one term a
// cycle, and the coefficient memory port must fetch the occupied coefficient in
// a state of its own (S_OCC) before the terms of each occupied band. Reads
// outside num_basis skip the pipeline and go straight to S_FIN with all-zero
// fields. A two-entry command queue accepts new items while the back end works,
// and a result register holds one finished result until it is popped.
module transition_density_matrix_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [tdm_pkg::OP_W-1:0]            i_op,
    input  logic [tdm_pkg::IDX_W-1:0]           i_row,
    input  logic [tdm_pkg::IDX_W-1:0]           i_col,
    input  logic signed [tdm_pkg::VAL_W-1:0]    i_value_re,
    input  logic signed [tdm_pkg::VAL_W-1:0]    i_value_im,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [tdm_pkg::OUT_W-1:0]    o_dm_re,
    output logic signed [tdm_pkg::OUT_W-1:0]    o_dm_im,
    output logic                                o_saturated,
    input  logic                                i_cfg_we,
    input  logic [tdm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tdm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    tdm_pkg::t_cfg r_cfg;
    tdm_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          take;
    logic          out_valid;
    logic          pop_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nocc   <= tdm_pkg::OCNT_W'(1);
            r_cfg.nvirt  <= tdm_pkg::VCNT_W'(1);
            r_cfg.nbasis <= tdm_pkg::NB_W'(tdm_pkg::MAX_BASIS);
            r_cfg.cplx   <= 1'b0;
            r_cfg.renorm <= 1'b0;
            r_cfg.recip  <= tdm_pkg::RECIP_W'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tdm_pkg::REG_NOCC: begin
                    r_cfg.nocc <= (32'(i_cfg_data[5:0]) < tdm_pkg::MAX_OCC)
                        ? tdm_pkg::OCNT_W'(i_cfg_data[5:0])
                        : tdm_pkg::OCNT_W'(tdm_pkg::MAX_OCC);
                end
                tdm_pkg::REG_NVIRT: begin
                    r_cfg.nvirt <= (32'(i_cfg_data[5:0]) < tdm_pkg::MAX_VIRT)
                        ? tdm_pkg::VCNT_W'(i_cfg_data[5:0])
                        : tdm_pkg::VCNT_W'(tdm_pkg::MAX_VIRT);
                end
                tdm_pkg::REG_NBASIS: begin
                    r_cfg.nbasis <= (32'(i_cfg_data[6:0]) < tdm_pkg::MAX_BASIS)
                        ? tdm_pkg::NB_W'(i_cfg_data[6:0])
                        : tdm_pkg::NB_W'(tdm_pkg::MAX_BASIS);
                end
                tdm_pkg::REG_CPLX:   r_cfg.cplx   <= i_cfg_data[0];
                tdm_pkg::REG_RENORM: r_cfg.renorm <= i_cfg_data[0];
                tdm_pkg::REG_RECIP:  r_cfg.recip  <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    tdm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value_re  (i_value_re),
        .i_value_im  (i_value_im),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_take      (take)
    );

    assign empty  = !out_valid;
    assign pop_ok = pop && out_valid;

    tdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_take      (take),
        .i_pop       (pop_ok),
        .o_valid     (out_valid),
        .o_dm_re     (o_dm_re),
        .o_dm_im     (o_dm_im),
        .o_saturated (o_saturated)
    );
endmodule

@@ test/tdm_element_check.sv @@
// Checker for the transition density matrix core: watches the item, result and
// register channels, predicts each density element and compares it field by field.
// Depends on tdm_pkg.
`timescale 1ns / 100ps

module tdm_element_check
    import tdm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [OP_W-1:0]             i_op,
    input  logic [IDX_W-1:0]            i_row,
    input  logic [IDX_W-1:0]            i_col,
    input  logic [VAL_W-1:0]            i_value_re,
    input  logic [VAL_W-1:0]            i_value_im,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [OUT_W-1:0]            i_dm_re,
    input  logic [OUT_W-1:0]            i_dm_im,
    input  logic                        i_saturated,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output int                          o_errors,
    output int                          o_pending
);

    typedef struct packed {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        logic             sat;
    } t_element;

    localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48 = -MAX48 - 1;

    logic [WORD_W-1:0] coef_mem [COEF_DEPTH];
    logic [WORD_W-1:0] amp_mem [AMP_DEPTH];
    t_element          element_q [$];

    logic [5:0]  nocc_reg;
    logic [5:0]  nvirt_reg;
    logic [6:0]  nbasis_reg;
    logic        cplx_reg;
    logic        renorm_reg;
    logic [15:0] recip_reg;

    function automatic longint round_q15(input longint x);
        return (x + ROUND_HALF) >>> FRAC;
    endfunction

    function automatic longint clip48(input longint x, inout logic sat);
        if (x > MAX48) begin
            sat = 1'b1;
            return MAX48;
        end
        if (x < MIN48) begin
            sat = 1'b1;
            return MIN48;
        end
        return x;
    endfunction

    function automatic t_element density_element(input int r, input int c);
        int nocc, nvirt, nb, mu, nu;
        longint acc_re, acc_im, cr, ci, xr, xi, vr, vi, pr, pi, res_re, res_im, rl;
        logic [WORD_W-1:0] w;
        logic sat;
        t_element e;
        nocc = (nocc_reg > MAX_OCC) ? MAX_OCC : nocc_reg;
        nvirt = (nvirt_reg > MAX_VIRT) ? MAX_VIRT : nvirt_reg;
        nb = (nbasis_reg > MAX_BASIS) ? MAX_BASIS : nbasis_reg;
        e = '0;
        sat = 1'b0;
        if (r >= nb || c >= nb)
            return e;
        mu = cplx_reg ? c : r;
        nu = cplx_reg ? r : c;
        acc_re = 0;
        acc_im = 0;
        for (int j = 0; j < nocc; j++) begin
            w = coef_mem[j * MAX_BASIS + mu];
            cr = $signed(w[15:0]);
            ci = cplx_reg ? longint'($signed(w[31:16])) : 0;
            for (int b = 0; b < nvirt; b++) begin
                w = amp_mem[j * MAX_VIRT + b];
                xr = $signed(w[15:0]);
                xi = cplx_reg ? longint'($signed(w[31:16])) : 0;
                w = coef_mem[(nocc + b) * MAX_BASIS + nu];
                vr = $signed(w[15:0]);
                vi = cplx_reg ? longint'($signed(w[31:16])) : 0;
                pr = cr * xr + ci * xi;
                pi = cr * xi - ci * xr;
                acc_re += pr * vr - pi * vi;
                acc_im += pr * vi + pi * vr;
            end
        end
        res_re = round_q15(acc_re);
        res_im = cplx_reg ? round_q15(acc_im) : 0;
        if (cplx_reg && renorm_reg) begin
            rl = recip_reg;
            res_re = round_q15(res_re * rl);
            res_im = round_q15(res_im * rl);
        end
        res_re = clip48(res_re, sat);
        res_im = clip48(res_im, sat);
        e.re = res_re[OUT_W-1:0];
        e.im = res_im[OUT_W-1:0];
        e.sat = sat;
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_element got, want;
        if (!i_rst_n) begin
            nocc_reg <= 6'd1;
            nvirt_reg <= 6'd1;
            nbasis_reg <= 7'd64;
            cplx_reg <= 1'b0;
            renorm_reg <= 1'b0;
            recip_reg <= 16'd32768;
        end else begin
            if (pop && !empty) begin
                got = '{i_dm_re, i_dm_im, i_saturated};
                if (element_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected transaction: re %h im %h sat %b",
                                 got.re, got.im, got.sat);
                end else begin
                    want = element_q.pop_front();
                    if (got.re !== want.re || got.im !== want.im || got.sat !== want.sat) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: re %h/%h im %h/%h sat %b/%b (exp/act)",
                                     want.re, got.re, want.im, got.im, want.sat, got.sat);
                    end
                end
            end
            if (push && !full) begin
                case (i_op)
                    OP_COEF:
                        coef_mem[i_row * MAX_BASIS + i_col] = {i_value_im, i_value_re};
                    OP_AMP:
                        if (i_row < MAX_OCC && i_col < MAX_VIRT)
                            amp_mem[i_row * MAX_VIRT + i_col] = {i_value_im, i_value_re};
                    OP_READ:
                        element_q.push_back(density_element(i_row, i_col));
                    default: ;
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NOCC:   nocc_reg <= i_cfg_data[5:0];
                    REG_NVIRT:  nvirt_reg <= i_cfg_data[5:0];
                    REG_NBASIS: nbasis_reg <= i_cfg_data[6:0];
                    REG_CPLX:   cplx_reg <= i_cfg_data[0];
                    REG_RENORM: renorm_reg <= i_cfg_data[0];
                    REG_RECIP:  recip_reg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = element_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

@@ test/transition_density_matrix_core_tb.sv @@
// Testbench top for the transition density matrix core: clock, reset, register
// phases and item stimulus with random idling. Depends on tdm_pkg, the core and
// tdm_element_check, which predicts and compares.
`timescale 1ns / 100ps

module transition_density_matrix_core_tb;
    import tdm_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [OP_W-1:0]       i_op;
    logic [IDX_W-1:0]      i_row;
    logic [IDX_W-1:0]      i_col;
    logic [VAL_W-1:0]      i_value_re;
    logic [VAL_W-1:0]      i_value_im;
    logic                  empty;
    logic                  pop;
    logic [OUT_W-1:0]      o_dm_re;
    logic [OUT_W-1:0]      o_dm_im;
    logic                  o_saturated;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    pending;

    bit coef_written [COEF_DEPTH];
    bit amp_written [AMP_DEPTH];
    int cur_nocc, cur_nvirt, cur_nb;
    bit cur_cplx;
    bit steady;
    bit hold_req;
    int cycles;

    transition_density_matrix_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_op(i_op),
        .i_row(i_row), .i_col(i_col), .i_value_re(i_value_re), .i_value_im(i_value_im),
        .empty(empty), .pop(pop), .o_dm_re(o_dm_re), .o_dm_im(o_dm_im),
        .o_saturated(o_saturated), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    tdm_element_check u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_op(i_op),
        .i_row(i_row), .i_col(i_col), .i_value_re(i_value_re), .i_value_im(i_value_im),
        .empty(empty), .pop(pop), .i_dm_re(o_dm_re), .i_dm_im(o_dm_im),
        .i_saturated(o_saturated), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("transition_density_matrix_core test failed");
            $finish;
        end
    end

    initial begin
        pop <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic offer(input logic [OP_W-1:0] op, input int r, input int c,
                         input logic [15:0] re, input logic [15:0] im);
        if (!steady && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_row <= IDX_W'(r);
        i_col <= IDX_W'(c);
        i_value_re <= re;
        i_value_im <= im;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (op == OP_COEF)
            coef_written[r * MAX_BASIS + c] = 1'b1;
        else if (op == OP_AMP && r < MAX_OCC && c < MAX_VIRT)
            amp_written[r * MAX_VIRT + c] = 1'b1;
    endtask

    task automatic offer_rand(input logic [OP_W-1:0] op, input int r, input int c);
        offer(op, r, c, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    // load every entry an in-range read of (r, c) touches that has not been written yet, then offer the read
    task automatic read_element(input int r, input int c);
        int mu, nu;
        if (r < cur_nb && c < cur_nb) begin
            mu = cur_cplx ? c : r;
            nu = cur_cplx ? r : c;
            for (int j = 0; j < cur_nocc; j++) begin
                if (!coef_written[j * MAX_BASIS + mu])
                    offer_rand(OP_COEF, j, mu);
                for (int b = 0; b < cur_nvirt; b++) begin
                    if (!amp_written[j * MAX_VIRT + b])
                        offer_rand(OP_AMP, j, b);
                    if (!coef_written[(cur_nocc + b) * MAX_BASIS + nu])
                        offer_rand(OP_COEF, cur_nocc + b, nu);
                end
            end
        end
        offer_rand(OP_READ, r, c);
    endtask

    task automatic drain();
        push <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        @(posedge i_clk);
    endtask

    task automatic set_cfg(input int nocc, input int nvirt, input int nb,
                           input bit cx, input bit rn, input int recip);
        drain();
        write_reg(REG_NOCC, nocc);
        write_reg(REG_NVIRT, nvirt);
        write_reg(REG_NBASIS, nb);
        write_reg(REG_CPLX, cx);
        write_reg(REG_RENORM, rn);
        write_reg(REG_RECIP, recip);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_nocc = (nocc > MAX_OCC) ? MAX_OCC : nocc;
        cur_nvirt = (nvirt > MAX_VIRT) ? MAX_VIRT : nvirt;
        cur_nb = (nb > MAX_BASIS) ? MAX_BASIS : nb;
        cur_cplx = cx;
    endtask

    task automatic run_phase(input int n);
        int k, r, c;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                r = ($urandom_range(0, 4) != 0) ?
                    $urandom_range(0, cur_nocc + cur_nvirt - 1) : $urandom_range(0, 63);
                c = ($urandom_range(0, 4) != 0 && cur_nb > 0) ?
                    $urandom_range(0, cur_nb - 1) : $urandom_range(0, 63);
                offer_rand(OP_COEF, r, c);
            end else if (k < 65) begin
                r = ($urandom_range(0, 6) != 0) ?
                    $urandom_range(0, cur_nocc - 1) : $urandom_range(0, 63);
                c = ($urandom_range(0, 6) != 0) ?
                    $urandom_range(0, cur_nvirt - 1) : $urandom_range(0, 63);
                offer_rand(OP_AMP, r, c);
            end else if (k < 95) begin
                r = ($urandom_range(0, 6) != 0 && cur_nb > 0) ?
                    $urandom_range(0, cur_nb - 1) : $urandom_range(0, 63);
                c = ($urandom_range(0, 6) != 0 && cur_nb > 0) ?
                    $urandom_range(0, cur_nb - 1) : $urandom_range(0, 63);
                read_element(r, c);
            end else begin
                offer_rand(OP_SPARE, $urandom_range(0, 63), $urandom_range(0, 63));
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_op <= OP_COEF;
        i_row <= '0;
        i_col <= '0;
        i_value_re <= '0;
        i_value_im <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_NOCC;
        i_cfg_data <= '0;
        cycles = 0;
        steady = 1'b0;
        hold_req = 1'b0;
        cur_nocc = 1;
        cur_nvirt = 1;
        cur_nb = 64;
        cur_cplx = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(OP_COEF, 0, 0, 16'h7FFF, 16'h8000);
        offer(OP_COEF, 1, 0, 16'h8000, 16'h7FFF);
        offer(OP_AMP, 0, 0, 16'h8000, 16'h8000);
        offer(OP_COEF, 63, 63, 16'h8000, 16'h8000);
        offer(OP_AMP, 63, 63, 16'h7FFF, 16'h7FFF);
        offer(OP_AMP, 5, 40, 16'h1234, 16'h5678);
        offer(OP_SPARE, 63, 63, 16'hFFFF, 16'hFFFF);
        read_element(0, 0);
        read_element(0, 63);
        read_element(63, 0);
        read_element(63, 63);

        set_cfg(1, 1, 64, 1, 1, 32768);
        offer(OP_COEF, 0, 0, 16'h8000, 16'h8000);
        offer(OP_COEF, 1, 0, 16'h8000, 16'h7FFF);
        offer(OP_AMP, 0, 0, 16'h7FFF, 16'h8000);
        read_element(0, 0);
        read_element(0, 1);

        set_cfg(2, 3, 64, 1, 1, 32768);
        hold_req = 1'b1;
        run_phase(35);
        set_cfg(1, 1, 1, 0, 0, 0);
        run_phase(20);
        set_cfg(32, 1, 64, 1, 1, 65535);
        run_phase(15);
        set_cfg(1, 32, 64, 0, 1, 1);
        run_phase(15);
        set_cfg(40, 1, 127, 1, 0, 0);
        run_phase(10);
        set_cfg(1, 63, 0, 1, 1, 16384);
        run_phase(15);
        set_cfg(3, 2, 16, 1, 1, $urandom_range(0, 65535));
        run_phase(35);
        steady = 1'b1;
        set_cfg(4, 4, 64, 1, 1, 40000);
        run_phase(40);
        drain();

        if (errors == 0)
            $display("transition_density_matrix_core test passed");
        else
            $display("transition_density_matrix_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tdm_pkg.sv
rtl/tdm_ram.sv
rtl/tdm_front.sv
rtl/tdm_back.sv
rtl/transition_density_matrix_core.sv
test/tdm_element_check.sv
test/transition_density_matrix_core_tb.sv
